FILE: hw/rtl/ctrd_pkg.sv
// Package for the CTR_DRBG AES-256 block: types, mode codes, AES helper functions.
// No dependencies.
package ctrd_pkg;

  typedef enum logic [1:0] {
    MODE_SEED = 2'd0,
    MODE_GEN  = 2'd1,
    MODE_END  = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  localparam int unsigned SEED_WORDS_C = 6;
  localparam logic [31:0] REQ_MAX = 32'hffff_ffff;

  typedef struct packed {
    logic         start;
    logic [255:0] key;
    logic [127:0] block;
  } aes_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] block;
  } aes_rsp_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a 128-bit state, byte 0 in the top bits
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[127 - 8*(i + 4*c) -: 8] = sbox(s[127 - 8*(i + 4*((c + i) & 3)) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32*c -: 8];
      a1 = s[119 - 32*c -: 8];
      a2 = s[111 - 32*c -: 8];
      a3 = s[103 - 32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32*c -: 8] = a0 ^ al ^ xt(a0 ^ a1);
      t[119 - 32*c -: 8] = a1 ^ al ^ xt(a1 ^ a2);
      t[111 - 32*c -: 8] = a2 ^ al ^ xt(a2 ^ a3);
      t[103 - 32*c -: 8] = a3 ^ al ^ xt(a3 ^ a0);
    end
    return t;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage

FILE: hw/rtl/ctrd_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on nothing.
interface ctrd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [2:0]  word_index;
  logic [63:0] entropy_word;
  logic [63:0] personal_word;
  modport source (output valid, mode, word_index, entropy_word, personal_word, input ready);
  modport sink (input valid, mode, word_index, entropy_word, personal_word, output ready);
endinterface

interface ctrd_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic [31:0] requests_served;
  modport source (output valid, block_high, block_low, requests_served, input ready);
  modport sink (input valid, block_high, block_low, requests_served, output ready);
endinterface

FILE: hw/rtl/ctrd_aes.sv
// Iterative AES-256 encryption core: one round per cycle, key expanded on the fly.
// Depends on ctrd_pkg.
module ctrd_aes (
  input  logic               clk,
  input  logic               rst,
  input  ctrd_pkg::aes_req_t req,
  output ctrd_pkg::aes_rsp_t rsp
);

  logic         busy;
  logic [3:0]   round;
  logic [127:0] state;
  logic [255:0] kw;     // sliding window: previous two round keys
  logic [7:0]   rc;
  logic [127:0] rk;     // round key for current round
  logic [127:0] rk_next_half;
  logic [127:0] rnd_out;
  logic [127:0] ss;

  // next 4 expanded words; even rounds rotate and add rcon, odd rounds substitute only
  always_comb begin
    logic [31:0] w0, w1, w2, w3, tmp;
    if (!round[0]) begin
      tmp = ctrd_pkg::sub_word(kw[31:0]);
      tmp = {tmp[23:0], tmp[31:24]} ^ {rc, 24'h0};
    end else begin
      tmp = ctrd_pkg::sub_word(kw[31:0]);
    end
    w0 = kw[255:224] ^ tmp;
    w1 = kw[223:192] ^ w0;
    w2 = kw[191:160] ^ w1;
    w3 = kw[159:128] ^ w2;
    rk_next_half = {w0, w1, w2, w3};
  end

  // round 1 uses key words 4..7 (kw low half), later rounds use fresh words
  assign rk = (round == 4'd1) ? kw[127:0] : rk_next_half;
  assign ss = ctrd_pkg::sub_shift(state);
  assign rnd_out = ((round == 4'd14) ? ss : ctrd_pkg::mix_cols(ss)) ^ rk;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      round <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        round <= 4'd1;
        rc <= 8'h01;
        state <= req.block ^ req.key[255:128];
        kw <= req.key;
      end else if (busy) begin
        state <= rnd_out;
        if (round != 4'd1) begin
          kw <= {kw[127:0], rk_next_half};
          if (round[0]) rc <= ctrd_pkg::xt(rc);
        end
        if (round == 4'd14) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
        end
        round <= round + 4'd1;
      end
    end
  end

  assign rsp.block = state;

endmodule

FILE: hw/rtl/ctr_drbg_aes256.sv
// CTR_DRBG (AES-256, no derivation function) top level.
// Depends on ctrd_pkg, ctrd_if, ctrd_aes.
//
// Usage:
//   req channel carries one request: mode, word_index, entropy_word, personal_word.
//   Mode 0 stores entropy^personal as seed word word_index (0..5, big-endian);
//   word 5 instantiates: key cleared, V set to 1, update run with the seed, count = 1.
//   Mode 1 steps V and returns one AES-256 block on the rsp channel together
//   with the request count. Mode 2 runs the update with no data and bumps the
//   request count (saturating). Indices 6/7 and mode 3 are dropped.
// Timing:
//   One shared AES core does one round per cycle.
//   Generate: encrypt in S_ENC/S_WAIT, result in S_OUT; the next request can be
//   accepted at the edge after the result is taken.
//   Update (mode 0 word 5, mode 2): three encryptions, then key and V load in S_UPD.
//   Plain seed-word loads and dropped requests keep the block idle, ready high.
//   req.ready is low while a request is in work and while a result waits.
// Reset: key, V and request count cleared; seed words undefined until written.
// Stall: a result holds on rsp until taken; the next request waits for that.
module ctr_drbg_aes256 (
  input logic clk,
  input logic rst,
  ctrd_req_if.sink   req,
  ctrd_rsp_if.source rsp
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ENC  = 5'b00010,
    S_WAIT = 5'b00100,
    S_UPD  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t        st;
  logic [255:0]  key;
  logic [127:0]  v;
  logic [63:0]   seed [ctrd_pkg::SEED_WORDS_C];
  logic [31:0]   req_count;
  logic [383:0]  tmp;       // collected keystream for update
  logic [1:0]    nblk;      // encryptions done in this update
  logic          is_upd;
  logic          with_data;
  ctrd_pkg::aes_req_t aq;
  ctrd_pkg::aes_rsp_t ar;

  ctrd_aes u_aes (.clk(clk), .rst(rst), .req(aq), .rsp(ar));

  assign req.ready = (st == S_IDLE);
  assign aq.key    = key;
  assign aq.block  = v;
  assign aq.start  = (st == S_ENC);

  assign rsp.valid = (st == S_OUT);

  always_ff @(posedge clk) begin
    if (req.valid && req.ready && req.mode == ctrd_pkg::MODE_SEED && req.word_index < 3'd6)
      seed[req.word_index] <= req.entropy_word ^ req.personal_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      key <= '0;
      v <= '0;
      req_count <= '0;
    end else begin
      case (st)
        S_IDLE: begin
          if (req.valid) begin
            nblk <= 2'd0;
            case (req.mode)
              ctrd_pkg::MODE_SEED: begin
                if (req.word_index == 3'd5) begin
                  key <= '0;
                  v <= 128'd1;
                  is_upd <= 1'b1;
                  with_data <= 1'b1;
                  req_count <= 32'd1;
                  st <= S_ENC;
                end
              end
              ctrd_pkg::MODE_GEN: begin
                v <= v + 128'd1;
                is_upd <= 1'b0;
                st <= S_ENC;
              end
              ctrd_pkg::MODE_END: begin
                v <= v + 128'd1;
                is_upd <= 1'b1;
                with_data <= 1'b0;
                if (req_count != ctrd_pkg::REQ_MAX) req_count <= req_count + 32'd1;
                st <= S_ENC;
              end
              default: ;
            endcase
          end
        end
        S_ENC: st <= S_WAIT;
        S_WAIT: begin
          if (ar.done) begin
            if (!is_upd) begin
              rsp.block_high <= ar.block[127:64];
              rsp.block_low <= ar.block[63:0];
              rsp.requests_served <= req_count;
              st <= S_OUT;
            end else begin
              tmp <= {tmp[255:0], ar.block};
              nblk <= nblk + 2'd1;
              if (nblk == 2'd2) begin
                st <= S_UPD;
              end else begin
                v <= v + 128'd1;
                st <= S_ENC;
              end
            end
          end
        end
        S_UPD: begin
          if (with_data) begin
            key <= tmp[383:128] ^ {seed[0], seed[1], seed[2], seed[3]};
            v <= tmp[127:0] ^ {seed[4], seed[5]};
          end else begin
            key <= tmp[383:128];
            v <= tmp[127:0];
          end
          st <= S_IDLE;
        end
        S_OUT: if (rsp.ready) st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/ctrd_check.sv
// Port-level checker for the CTR_DRBG block, bound to the top level.
// Depends on the top level's ports only.
module ctrd_check (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic [63:0] rsp_high
);
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_high))
    else $error("result dropped while stalled");
  a_no_accept_with_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("request taken while result pending");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !rsp_valid)
    else $error("result too early");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result after reset");
endmodule

bind ctr_drbg_aes256 ctrd_check u_check (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_high(rsp.block_high)
);

FILE: verif/ctrd_tb_if.sv
// The testbench uses the channel interfaces ctrd_req_if and ctrd_rsp_if
// defined with the RTL in hw/rtl/ctrd_if.sv; nothing is declared here.

FILE: verif/ctr_drbg_aes256_tb.sv
// Testbench for ctr_drbg_aes256: random and directed seed/generate/end requests,
// blocks checked against an in-bench AES-256 CTR_DRBG predictor.
// Depends on ctrd_pkg, the channel interfaces and the RTL.
module ctr_drbg_aes256_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    ctrd_pkg::mode_t mode;
    logic [2:0]  word_index;
    logic [63:0] entropy_word;
    logic [63:0] personal_word;
  } drbg_req_t;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [31:0] requests_served;
  } drbg_blk_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #2 clk = ~clk;

  ctrd_req_if req ();
  ctrd_rsp_if rsp ();

  ctr_drbg_aes256 DUT (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));

  drbg_req_t pending_reqs[$];
  drbg_blk_t expected_blocks[$];
  bit        stim_done = 1'b0;
  int        mismatches = 0;
  longint    cycle_count = 0;

  // Predictor state: key, V, seed words and request count
  logic [255:0] drbg_key;
  logic [127:0] drbg_v;
  logic [63:0]  seed_words [6];
  logic [31:0]  drbg_reqs;

  // --- AES-256 written out byte-wise, byte 0 in the top bits ---
  logic [7:0] sb_tab [256];
  initial begin
    for (int i = 0; i < 256; i++) sb_tab[i] = ctrd_pkg::sbox(8'(i));
  end

  function automatic logic [7:0] gmul2(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes256_enc(input logic [255:0] k, input logic [127:0] pt);
    logic [7:0] w [240];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, x, al, rc;
    logic [127:0] ct;
    rc = 8'h01;
    for (int i = 0; i < 32; i++) w[i] = k[255 - 8*i -: 8];
    for (int i = 8; i < 60; i++) begin
      a0 = w[4*i-4]; a1 = w[4*i-3]; a2 = w[4*i-2]; a3 = w[4*i-1];
      if ((i & 7) == 0) begin
        x = a0;
        a0 = sb_tab[a1] ^ rc; a1 = sb_tab[a2]; a2 = sb_tab[a3]; a3 = sb_tab[x];
        rc = gmul2(rc);
      end else if ((i & 7) == 4) begin
        a0 = sb_tab[a0]; a1 = sb_tab[a1]; a2 = sb_tab[a2]; a3 = sb_tab[a3];
      end
      w[4*i] = w[4*i-32] ^ a0; w[4*i+1] = w[4*i-31] ^ a1;
      w[4*i+2] = w[4*i-30] ^ a2; w[4*i+3] = w[4*i-29] ^ a3;
    end
    for (int i = 0; i < 16; i++) s[i] = pt[127 - 8*i -: 8] ^ w[i];
    for (int r = 1; r <= 14; r++) begin
      for (int i = 0; i < 16; i++) s[i] = sb_tab[s[i]];
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[i + 4*c] = s[i + 4*((c + i) & 3)];
      if (r < 14) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ al ^ gmul2(a0 ^ a1);
          t[4*c+1] = a1 ^ al ^ gmul2(a1 ^ a2);
          t[4*c+2] = a2 ^ al ^ gmul2(a2 ^ a3);
          t[4*c+3] = a3 ^ al ^ gmul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ w[16*r + i];
    end
    for (int i = 0; i < 16; i++) ct[127 - 8*i -: 8] = s[i];
    return ct;
  endfunction

  // DRBG update: three counter blocks, optionally XORed with the seed words
  function automatic void drbg_refresh(input bit with_seed);
    logic [383:0] tmp;
    for (int i = 0; i < 3; i++) begin
      drbg_v = drbg_v + 128'd1;
      tmp[383 - 128*i -: 128] = aes256_enc(drbg_key, drbg_v);
    end
    if (with_seed)
      for (int i = 0; i < 6; i++) tmp[383 - 64*i -: 64] ^= seed_words[i];
    drbg_key = tmp[383:128];
    drbg_v   = tmp[127:0];
  endfunction

  // Apply one request to the predictor; queue the block it yields
  function automatic void predict_request(input drbg_req_t r);
    drbg_blk_t b;
    case (r.mode)
      ctrd_pkg::MODE_SEED: begin
        if (r.word_index < ctrd_pkg::SEED_WORDS_C) begin
          seed_words[r.word_index] = r.entropy_word ^ r.personal_word;
          if (r.word_index == ctrd_pkg::SEED_WORDS_C - 1) begin
            drbg_key = '0;
            drbg_v   = '0;
            drbg_refresh(1'b1);
            drbg_reqs = 32'd1;
          end
        end
      end
      ctrd_pkg::MODE_GEN: begin
        drbg_v = drbg_v + 128'd1;
        {b.block_high, b.block_low} = aes256_enc(drbg_key, drbg_v);
        b.requests_served = drbg_reqs;
        expected_blocks.push_back(b);
      end
      ctrd_pkg::MODE_END: begin
        drbg_refresh(1'b0);
        if (drbg_reqs != ctrd_pkg::REQ_MAX) drbg_reqs = drbg_reqs + 32'd1;
      end
      default: ;
    endcase
  endfunction

  // --- stimulus builders ---
  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic void push_req(input ctrd_pkg::mode_t m, input logic [2:0] idx,
                                   input logic [63:0] e, input logic [63:0] p);
    drbg_req_t r;
    r.mode = m; r.word_index = idx; r.entropy_word = e; r.personal_word = p;
    pending_reqs.push_back(r);
  endfunction

  // Full six-word seed; personalization sometimes absent (zero)
  function automatic void push_seed(input bit no_pers);
    for (int i = 0; i < 6; i++)
      push_req(ctrd_pkg::MODE_SEED, 3'(i), rnd64(), no_pers ? 64'd0 : rnd64());
  endfunction

  initial begin
    seed_words = '{default: '0};
    drbg_key = '0; drbg_v = '0; drbg_reqs = '0;
    // Directed: generate and end straight after reset (zero key and V),
    // extremes of the seed fields, dropped indices and the unused mode.
    push_req(ctrd_pkg::MODE_GEN, 3'd0, '0, '0);
    push_req(ctrd_pkg::MODE_END, 3'd7, '1, '1);
    push_req(ctrd_pkg::MODE_GEN, 3'd7, '1, '0);
    for (int i = 0; i < 6; i++) push_req(ctrd_pkg::MODE_SEED, 3'(i), '1, '0);
    push_req(ctrd_pkg::MODE_GEN, 3'd0, '0, '0);
    push_req(ctrd_pkg::MODE_SEED, 3'd6, '1, '1);
    push_req(ctrd_pkg::MODE_SEED, 3'd7, '1, '0);
    push_req(ctrd_pkg::MODE_NONE, 3'd3, '1, '1);
    push_req(ctrd_pkg::MODE_END, 3'd0, '0, '0);
    for (int i = 0; i < 6; i++) push_req(ctrd_pkg::MODE_SEED, 3'(i), '0, '1);
    push_req(ctrd_pkg::MODE_GEN, 3'd5, '0, '0);
    // Random: mostly full seeds followed by generate/end traffic, some noise
    while (pending_reqs.size() < 700) begin
      if ($urandom_range(0, 3) == 0) push_seed($urandom_range(0, 2) == 0);
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5:
            push_req(ctrd_pkg::MODE_GEN, 3'($urandom()), rnd64(), rnd64());
          6, 7: push_req(ctrd_pkg::MODE_END, 3'($urandom()), rnd64(), rnd64());
          8: push_req(ctrd_pkg::MODE_NONE, 3'($urandom()), rnd64(), rnd64());
          default:
            push_req(ctrd_pkg::MODE_SEED, 3'($urandom_range(0, 7)), rnd64(), rnd64());
        endcase
      end
    end
    stim_done = 1'b1;
  end

  // --- driver: bursts of back-to-back requests with random gaps ---
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.mode <= ctrd_pkg::MODE_NONE; req.word_index <= '0;
      req.entropy_word <= '0; req.personal_word <= '0;
    end else if (!req.valid || req.ready) begin
      // previous request (if any) was taken at this edge
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req.valid <= 1'b0;
      end else if (pending_reqs.size() > 0 && stim_done) begin
        drbg_req_t r;
        r = pending_reqs.pop_front();
        predict_request(r);
        req.valid <= 1'b1;
        req.mode <= r.mode; req.word_index <= r.word_index;
        req.entropy_word <= r.entropy_word; req.personal_word <= r.personal_word;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 15);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // --- receiver: stall pattern of its own; long runs with no stall ---
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      stall_phase <= (stall_phase + 1) % 200;
      if (stall_phase < 60) rsp.ready <= 1'b1;
      else rsp.ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 23 != 0);
    end
  end

  // --- monitor: compare every block with the oldest prediction ---
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected block %h %h", rsp.block_high, rsp.block_low);
      end else begin
        drbg_blk_t e;
        e = expected_blocks.pop_front();
        if (rsp.block_high !== e.block_high || rsp.block_low !== e.block_low ||
            rsp.requests_served !== e.requests_served) begin
          mismatches++;
          if (mismatches <= 10)
            $display("block mismatch: exp %h %h %h got %h %h %h",
                     e.block_high, e.block_low, e.requests_served,
                     rsp.block_high, rsp.block_low, rsp.requests_served);
        end
      end
    end
  end

  // --- reset, end of run and watchdog ---
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done);
    while (pending_reqs.size() > 0 || req.valid || expected_blocks.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);   // an update still in work drains here
    if (mismatches == 0 && expected_blocks.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end
endmodule

FILE: files.f
hw/rtl/ctrd_pkg.sv
hw/rtl/ctrd_if.sv
hw/rtl/ctrd_aes.sv
hw/rtl/ctr_drbg_aes256.sv
hw/rtl/ctrd_check.sv
verif/ctrd_tb_if.sv
verif/ctr_drbg_aes256_tb.sv
